FILE: hw/rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg: shared widths, types and codes for the linear fit block
// Sizes follow from the point store depth and the fixed field widths.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam int MAX_POINTS = 8;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	localparam int PWM_W   = 8;
	localparam int RPM_W   = 16;
	localparam int STORE_W = PWM_W + RPM_W;
	localparam int CFG_W   = 16;
	localparam int MVP_W   = 4;
	localparam int FRAC    = 20;

	localparam int SX_W  = RPM_W + CNT_W;
	localparam int SY_W  = PWM_W + CNT_W;
	localparam int SXY_W = RPM_W + PWM_W + CNT_W;
	localparam int SXX_W = 2 * RPM_W + CNT_W;

	localparam int D_W   = CNT_W + SXX_W;
	localparam int NUM_W = CNT_W + SXY_W + 1;
	localparam int ICP_W = 32 + SX_W + 1;
	localparam int ICN_W = ICP_W + 1;
	localparam int DVD_A = NUM_W + FRAC - 1;
	localparam int DVD_B = ICP_W;
	localparam int DVD_W = (DVD_A > DVD_B) ? DVD_A : DVD_B;
	localparam int DIV_STEPS = DVD_W;

	localparam int EP_W  = 32 + RPM_W + 1;
	localparam int E_W   = EP_W + 1;
	localparam int AE_W  = 48;
	localparam int HALF  = AE_W / 2;
	localparam int SQ_W  = 2 * AE_W;
	localparam int RES_W = SQ_W + CNT_W;
	localparam int RN_W  = RES_W + CNT_W;
	localparam int RN2_W = RES_W + 2 * CNT_W;
	localparam int DV_W  = PWM_W + CNT_W;
	localparam int TOT_W = 2 * DV_W + CNT_W;
	localparam int LV_W  = CFG_W + 1 + TOT_W;

	localparam int RES_DRAIN = 8;
	localparam int SEQ_W = $clog2(DIV_STEPS + MAX_POINTS + RES_DRAIN + 1);

	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [MVP_W-1:0]          mvp_t;
	typedef logic [SX_W-1:0]           sx_t;
	typedef logic [SY_W-1:0]           sy_t;
	typedef logic [SXY_W-1:0]          sxy_t;
	typedef logic [SXX_W-1:0]          sxx_t;
	typedef logic [D_W-1:0]            d_t;
	typedef logic [D_W:0]              rem_t;
	typedef logic signed [NUM_W-1:0]   num_t;
	typedef logic [NUM_W-1:0]          numu_t;
	typedef logic [DVD_W-1:0]          dvd_t;
	typedef logic signed [ICP_W-1:0]   icp_t;
	typedef logic signed [ICN_W-1:0]   icn_t;
	typedef logic signed [31:0]        q16_t;
	typedef logic signed [EP_W-1:0]    ep_t;
	typedef logic signed [E_W-1:0]     e_t;
	typedef logic [AE_W-1:0]           ae_t;
	typedef logic [2*HALF-1:0]         pp_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [RES_W-1:0]          res_t;
	typedef logic [RN_W-1:0]           rn_t;
	typedef logic [RN2_W-1:0]          rn2_t;
	typedef logic [DV_W-1:0]           dv_t;
	typedef logic signed [DV_W:0]      dvx_t;
	typedef logic [2*DV_W-1:0]         dsq_t;
	typedef logic [TOT_W-1:0]          tot_t;
	typedef logic [LV_W-1:0]           lv_t;
	typedef logic [SEQ_W-1:0]          seq_t;
	typedef logic [2:0]                status_t;

	localparam cnt_t MAX_CNT   = cnt_t'(MAX_POINTS);
	localparam seq_t DIV_LAST  = seq_t'(DIV_STEPS - 1);
	localparam seq_t RES_TAIL  = seq_t'(RES_DRAIN - 1);

	localparam logic [CFG_W-1:0] MIN_FIT_RST = 16'd62259;
	localparam mvp_t             MIN_PTS_RST = 4'd3;

	localparam logic [0:0] REG_MIN_FIT = 1'b0;
	localparam logic [0:0] REG_MIN_PTS = 1'b1;

	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_FEW   = 3'd1;
	localparam status_t ST_DEG   = 3'd2;
	localparam status_t ST_SLOPE = 3'd3;
	localparam status_t ST_POOR  = 3'd4;

	typedef struct packed {
		logic    acc;
		logic    sums_clr;
		logic    fit_clr;
		logic    div_start;
		logic    div_sel;
		logic    div_step;
		logic    slope_ld;
		logic    icpt_ld;
		logic    acc_clr;
		logic    rd_en;
		addr_t   rd_addr;
		logic    out_ld;
		status_t status;
	} lfr_cmd_t;

	typedef struct packed {
		logic too_few;
		logic degen;
		logic slope_pos;
		logic good;
		cnt_t count;
	} lfr_sts_t;

endpackage

FILE: hw/rtl/lfr_if.sv
// ----------------------------------------------------------------------------
// lfr_if: point and fit result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lfr_pt_if;
	logic       valid;
	logic       ready;
	logic [7:0] pwm_value;
	logic [15:0] rpm_value;
	logic       point_valid;
	logic       last_point;

	modport source (output valid, pwm_value, rpm_value, point_valid, last_point, input ready);
	modport sink   (input valid, pwm_value, rpm_value, point_valid, last_point, output ready);
endinterface

interface lfr_fit_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] slope;
	logic signed [31:0] intercept;
	logic [2:0]         fit_status;
	logic [3:0]         points_used;

	modport source (output valid, slope, intercept, fit_status, points_used, input ready);
	modport sink   (input valid, slope, intercept, fit_status, points_used, output ready);
endinterface

FILE: hw/rtl/linear_fit_with_r_squared_check.sv
// ----------------------------------------------------------------------------
// linear_fit_with_r_squared_check: least-squares line fit with fit check
// Points are taken one per cycle while the sequencer is idle; a point with
// last_point set holds the input until its result is loaded. A full fit
// runs two 53-step serial divisions and the residual pass over the store;
// too few / degenerate points skip both, a non-positive slope skips the pass.
// Asynchronous active-low reset clears sums, count, state, config and valid flags.
// ----------------------------------------------------------------------------
module linear_fit_with_r_squared_check (
	input  logic                       clk,
	input  logic                       arst_n,
	lfr_pt_if.sink                     pts,
	lfr_fit_if.source                  fit,
	input  logic                       wr_en,
	input  logic [0:0]                 wr_idx,
	input  logic [lfr_pkg::CFG_W-1:0]  wr_data
);

	lfr_pkg::lfr_cmd_t cmd;
	lfr_pkg::lfr_sts_t sts;

	lfr_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pts.valid),
		.in_last  (pts.last_point),
		.in_ready (pts.ready),
		.out_valid(fit.valid),
		.out_ready(fit.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data),
		.pwm_value  (pts.pwm_value),
		.rpm_value  (pts.rpm_value),
		.point_valid(pts.point_valid),
		.slope      (fit.slope),
		.intercept  (fit.intercept),
		.fit_status (fit.fit_status),
		.points_used(fit.points_used)
	);

endmodule

FILE: hw/rtl/lfr_ram.sv
// ----------------------------------------------------------------------------
// lfr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/lfr_dp.sv
// ----------------------------------------------------------------------------
// lfr_dp: fit datapath
// Running sums, point store, shared serial divider, residual pipeline and
// the final exact R-squared compare.
// ----------------------------------------------------------------------------
module lfr_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lfr_pkg::lfr_cmd_t       cmd,
	output lfr_pkg::lfr_sts_t       sts,
	input  logic                    wr_en,
	input  logic [0:0]              wr_idx,
	input  logic [lfr_pkg::CFG_W-1:0] wr_data,
	input  logic [7:0]              pwm_value,
	input  logic [15:0]             rpm_value,
	input  logic                    point_valid,
	output logic signed [31:0]      slope,
	output logic signed [31:0]      intercept,
	output logic [2:0]              fit_status,
	output logic [3:0]              points_used
);

	logic [lfr_pkg::CFG_W-1:0] min_fit_q;
	lfr_pkg::mvp_t             min_pts_q;

	lfr_pkg::cnt_t cnt_q;
	lfr_pkg::sx_t  sum_x_q;
	lfr_pkg::sy_t  sum_y_q;
	lfr_pkg::sxy_t sum_xy_q;
	lfr_pkg::sxx_t sum_xx_q;
	logic          take;
	logic [lfr_pkg::RPM_W+lfr_pkg::PWM_W-1:0] xy;
	logic [2*lfr_pkg::RPM_W-1:0]              xx;
	logic [lfr_pkg::STORE_W-1:0]              rd_data;

	lfr_pkg::d_t    p_nxx_q, p_sxsx_q, d_q;
	lfr_pkg::numu_t p_nxy_q, p_sxsy_q, num_abs;
	lfr_pkg::num_t  num_q;

	lfr_pkg::dvd_t dvd_q, icn_abs;
	lfr_pkg::d_t   dvs_q;
	lfr_pkg::rem_t rem_q, rem_sh;
	logic          dneg_q, ge;
	logic          over_pos, over_neg;
	lfr_pkg::q16_t qsat, slope_q, icpt_q;
	lfr_pkg::icp_t icp_q;
	lfr_pkg::icn_t icn;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	lfr_pkg::ep_t  ep_s2;
	logic [lfr_pkg::PWM_W-1:0] py_s2;
	lfr_pkg::e_t   e_s3;
	lfr_pkg::dv_t  dv_s3;
	lfr_pkg::dvx_t dvx;
	lfr_pkg::ae_t  ae_s4;
	lfr_pkg::dsq_t dsq_s4, dsq_s5, dsq_s6;
	lfr_pkg::pp_t  hh_s5, hl_s5, ll_s5;
	lfr_pkg::sq_t  sq_s6;
	lfr_pkg::res_t res_q;
	lfr_pkg::tot_t tot_q;
	lfr_pkg::lv_t  lv_q;
	lfr_pkg::rn_t  rn_q;
	lfr_pkg::rn2_t rn2_q;
	logic [lfr_pkg::CFG_W:0] qinv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_fit_q <= lfr_pkg::MIN_FIT_RST;
			min_pts_q <= lfr_pkg::MIN_PTS_RST;
		end else if (wr_en) begin
			case (wr_idx)
				lfr_pkg::REG_MIN_FIT: min_fit_q <= wr_data;
				lfr_pkg::REG_MIN_PTS: min_pts_q <= wr_data[lfr_pkg::MVP_W-1:0];
				default: ;
			endcase
		end
	end

	// points beyond the store are dropped, not summed
	assign take = cmd.acc & point_valid & (cnt_q < lfr_pkg::MAX_CNT);
	assign xy   = rpm_value * pwm_value;
	assign xx   = rpm_value * rpm_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
		end else if (cmd.sums_clr) begin
			cnt_q    <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
		end else if (take) begin
			cnt_q    <= cnt_q + 1'b1;
			sum_x_q  <= sum_x_q + lfr_pkg::sx_t'(rpm_value);
			sum_y_q  <= sum_y_q + lfr_pkg::sy_t'(pwm_value);
			sum_xy_q <= sum_xy_q + lfr_pkg::sxy_t'(xy);
			sum_xx_q <= sum_xx_q + lfr_pkg::sxx_t'(xx);
		end
	end

	lfr_ram #(
		.WIDTH(lfr_pkg::STORE_W),
		.DEPTH(lfr_pkg::MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (take),
		.waddr(cnt_q[lfr_pkg::ADDR_W-1:0]),
		.wdata({pwm_value, rpm_value}),
		.raddr(cmd.rd_addr),
		.rdata(rd_data)
	);

	// normal equation terms, free running off the held sums
	always_ff @(posedge clk) begin
		p_nxx_q  <= lfr_pkg::d_t'(cnt_q) * lfr_pkg::d_t'(sum_xx_q);
		p_sxsx_q <= lfr_pkg::d_t'(sum_x_q) * lfr_pkg::d_t'(sum_x_q);
		p_nxy_q  <= lfr_pkg::numu_t'(cnt_q) * lfr_pkg::numu_t'(sum_xy_q);
		p_sxsy_q <= lfr_pkg::numu_t'(sum_x_q) * lfr_pkg::numu_t'(sum_y_q);
		d_q      <= p_nxx_q - p_sxsx_q;
		num_q    <= lfr_pkg::num_t'(p_nxy_q - p_sxsy_q);
		icp_q    <= lfr_pkg::icp_t'(slope_q) * lfr_pkg::icp_t'($signed({1'b0, sum_x_q}));
	end

	assign num_abs = num_q[lfr_pkg::NUM_W-1] ? lfr_pkg::numu_t'(-num_q) : lfr_pkg::numu_t'(num_q);
	assign icn     = lfr_pkg::icn_t'($signed({1'b0, sum_y_q, {lfr_pkg::FRAC{1'b0}}}))
	               - lfr_pkg::icn_t'(icp_q);
	assign icn_abs = icn[lfr_pkg::ICN_W-1] ? lfr_pkg::dvd_t'(-icn) : lfr_pkg::dvd_t'(icn);

	// restoring divider on magnitudes, one quotient bit per step
	assign rem_sh = {rem_q[lfr_pkg::D_W-1:0], dvd_q[lfr_pkg::DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			if (cmd.div_sel) begin
				dvd_q  <= icn_abs;
				dvs_q  <= lfr_pkg::d_t'({cnt_q, 4'b0000});
				dneg_q <= icn[lfr_pkg::ICN_W-1];
			end else begin
				dvd_q  <= lfr_pkg::dvd_t'({num_abs, {lfr_pkg::FRAC{1'b0}}});
				dvs_q  <= d_q;
				dneg_q <= num_q[lfr_pkg::NUM_W-1];
			end
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dvd_q <= {dvd_q[lfr_pkg::DVD_W-2:0], ge};
		end
	end

	assign over_pos = |dvd_q[lfr_pkg::DVD_W-1:31];
	assign over_neg = (|dvd_q[lfr_pkg::DVD_W-1:32]) | (dvd_q[31] & (|dvd_q[30:0]));

	always_comb begin
		if (dneg_q) begin
			qsat = over_neg ? 32'sh8000_0000 : lfr_pkg::q16_t'(-dvd_q[31:0]);
		end else begin
			qsat = over_pos ? 32'sh7fff_ffff : lfr_pkg::q16_t'(dvd_q[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fit_clr) begin
			slope_q <= '0;
			icpt_q  <= '0;
		end else begin
			if (cmd.slope_ld) begin
				slope_q <= qsat;
			end
			if (cmd.icpt_ld) begin
				icpt_q <= qsat;
			end
		end
	end

	// residual pass: one stored point enters per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign dvx = $signed({1'b0, lfr_pkg::dv_t'(cnt_q) * lfr_pkg::dv_t'(py_s2)})
	           - $signed({1'b0, sum_y_q});

	always_ff @(posedge clk) begin
		ep_s2  <= lfr_pkg::ep_t'(slope_q)
		        * lfr_pkg::ep_t'($signed({1'b0, rd_data[lfr_pkg::RPM_W-1:0]}));
		py_s2  <= rd_data[lfr_pkg::STORE_W-1:lfr_pkg::RPM_W];
		e_s3   <= lfr_pkg::e_t'($signed({1'b0, py_s2, {lfr_pkg::FRAC{1'b0}}}))
		        - lfr_pkg::e_t'(ep_s2) - lfr_pkg::e_t'($signed({icpt_q, 4'b0000}));
		dv_s3  <= dvx[lfr_pkg::DV_W] ? lfr_pkg::dv_t'(-dvx) : lfr_pkg::dv_t'(dvx);
		ae_s4  <= e_s3[lfr_pkg::E_W-1] ? lfr_pkg::ae_t'(-e_s3) : lfr_pkg::ae_t'(e_s3);
		dsq_s4 <= lfr_pkg::dsq_t'(dv_s3) * lfr_pkg::dsq_t'(dv_s3);
		hh_s5  <= lfr_pkg::pp_t'(ae_s4[lfr_pkg::AE_W-1:lfr_pkg::HALF])
		        * lfr_pkg::pp_t'(ae_s4[lfr_pkg::AE_W-1:lfr_pkg::HALF]);
		hl_s5  <= lfr_pkg::pp_t'(ae_s4[lfr_pkg::AE_W-1:lfr_pkg::HALF])
		        * lfr_pkg::pp_t'(ae_s4[lfr_pkg::HALF-1:0]);
		ll_s5  <= lfr_pkg::pp_t'(ae_s4[lfr_pkg::HALF-1:0])
		        * lfr_pkg::pp_t'(ae_s4[lfr_pkg::HALF-1:0]);
		dsq_s5 <= dsq_s4;
		sq_s6  <= (lfr_pkg::sq_t'(hh_s5) << (2 * lfr_pkg::HALF))
		        + (lfr_pkg::sq_t'(hl_s5) << (lfr_pkg::HALF + 1))
		        + lfr_pkg::sq_t'(ll_s5);
		dsq_s6 <= dsq_s5;
		if (cmd.acc_clr) begin
			res_q <= '0;
			tot_q <= '0;
		end else if (v_s6) begin
			res_q <= res_q + lfr_pkg::res_t'(sq_s6);
			tot_q <= tot_q + lfr_pkg::tot_t'(dsq_s6);
		end
		lv_q  <= lfr_pkg::lv_t'(qinv) * lfr_pkg::lv_t'(tot_q);
		rn_q  <= lfr_pkg::rn_t'(res_q) * lfr_pkg::rn_t'(cnt_q);
		rn2_q <= lfr_pkg::rn2_t'(rn_q) * lfr_pkg::rn2_t'(cnt_q);
	end

	assign qinv = {1'b1, {lfr_pkg::CFG_W{1'b0}}} - {1'b0, min_fit_q};

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			slope       <= slope_q;
			intercept   <= icpt_q;
			fit_status  <= cmd.status;
			points_used <= 4'(cnt_q);
		end
	end

	assign sts.too_few   = cnt_q < min_pts_q;
	assign sts.degen     = (d_q == '0);
	assign sts.slope_pos = !slope_q[31] && (slope_q != '0);
	assign sts.good      = lfr_pkg::rn2_t'({lv_q, 24'd0}) > rn2_q;
	assign sts.count     = cnt_q;

endmodule

FILE: hw/rtl/lfr_ctl.sv
// ----------------------------------------------------------------------------
// lfr_ctl: fit sequencer
// Accepts points, then steps the datapath through the fit, the residual
// pass and the hand-off of one result word.
// ----------------------------------------------------------------------------
module lfr_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lfr_pkg::lfr_sts_t sts,
	output lfr_pkg::lfr_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PROD = 4'd1;
	localparam logic [3:0] S_DIFF = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_DIV1 = 4'd4;
	localparam logic [3:0] S_SLP  = 4'd5;
	localparam logic [3:0] S_ICM  = 4'd6;
	localparam logic [3:0] S_ICS  = 4'd7;
	localparam logic [3:0] S_DIV2 = 4'd8;
	localparam logic [3:0] S_ICL  = 4'd9;
	localparam logic [3:0] S_RES  = 4'd10;
	localparam logic [3:0] S_EVAL = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0]       state_q, state_d;
	lfr_pkg::seq_t    cnt_q, cnt_d;
	lfr_pkg::status_t stat_q, stat_d;
	logic             ov_q;
	logic             out_free;

	assign out_free  = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		stat_d  = stat_q;
		cmd     = '0;
		cmd.status  = stat_q;
		cmd.rd_addr = cnt_q[lfr_pkg::ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				cmd.acc = in_valid;
				if (in_valid && in_last) begin
					state_d = S_PROD;
				end
			end
			S_PROD: begin
				cmd.fit_clr = 1'b1;
				state_d = S_DIFF;
			end
			S_DIFF: state_d = S_CHK;
			S_CHK: begin
				cnt_d = '0;
				if (sts.too_few) begin
					stat_d  = lfr_pkg::ST_FEW;
					state_d = S_FIN;
				end else if (sts.degen) begin
					stat_d  = lfr_pkg::ST_DEG;
					state_d = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIV1;
				end
			end
			S_DIV1: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == lfr_pkg::DIV_LAST) begin
					state_d = S_SLP;
				end
			end
			S_SLP: begin
				cmd.slope_ld = 1'b1;
				state_d = S_ICM;
			end
			// wait for slope times sum x to register
			S_ICM: state_d = S_ICS;
			S_ICS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				cnt_d = '0;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == lfr_pkg::DIV_LAST) begin
					state_d = S_ICL;
				end
			end
			S_ICL: begin
				cmd.icpt_ld = 1'b1;
				cmd.acc_clr = 1'b1;
				cnt_d = '0;
				if (!sts.slope_pos) begin
					stat_d  = lfr_pkg::ST_SLOPE;
					state_d = S_FIN;
				end else begin
					state_d = S_RES;
				end
			end
			// issue one read per cycle, then drain the residual pipeline
			S_RES: begin
				cmd.rd_en = cnt_q < lfr_pkg::seq_t'(sts.count);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == lfr_pkg::seq_t'(sts.count) + lfr_pkg::RES_TAIL) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				stat_d  = sts.good ? lfr_pkg::ST_OK : lfr_pkg::ST_POOR;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.sums_clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			stat_q  <= lfr_pkg::ST_OK;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			stat_q  <= stat_d;
			if (cmd.out_ld) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> out_free)
		else $error("result word loaded over an untaken one");

	a_load_ends_fit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> (state_q == S_IDLE) && ov_q)
		else $error("result load did not return to idle with a word pending");

	a_fit_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) && !sts.too_few && !sts.degen |=> (state_q == S_DIV1))
		else $error("non-degenerate fit did not start the slope division");

endmodule
